// File: hdl/dpr_pkg.sv
// Shared constants, register indexes and a helper function for the disparity reprojection block.
`default_nettype none
package dpr_pkg;

  localparam int DISPARITY_BITS = 16;
  localparam int DMAG_W = DISPARITY_BITS - 1;   // positive disparity magnitude
  localparam int DIV_W  = DMAG_W + 9;           // divisor: d<<8 (depth) or d<<1 (lateral)
  localparam int REM_W  = DIV_W + 1;
  localparam int QUO_W  = 25;                   // kept values stay below 2^25
  localparam int NUM_W  = 48;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_FOCAL        = 3'd2;
  localparam logic [IDX_W-1:0] REG_BASELINE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_DIVISOR      = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_DIST     = 3'd5;
  localparam logic [IDX_W-1:0] REG_COLOR_SRC    = 3'd6;

  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [19:0] RST_FOCAL        = 20'd184714;
  localparam logic [19:0] RST_BASELINE     = 20'd35389;
  localparam logic [6:0]  RST_DIVISOR      = 7'd16;
  localparam logic [15:0] RST_MAX_DIST     = 16'd25600;

  localparam logic [21:0] RAMP_FULL  = 22'd3276800;   // 50 m in Q16.16
  localparam logic [21:0] RAMP_ROUND = 22'd1638400;   // 25 m in Q16.16
  localparam logic [10:0] RECIP_50   = 11'd1310;      // floor(2^16 / 50), low side
  localparam logic [7:0]  GREEN_RAMP = 8'd128;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] nlo;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // One restoring division step: shift in the next numerator bit, subtract if it fits.
  function automatic div_lane_t div_step(input div_lane_t cur, input logic [DIV_W-1:0] dvs);
    div_lane_t        res;
    logic [REM_W-1:0] sh;
    sh = {cur.rem[REM_W-2:0], cur.nlo[QUO_W-1]};
    res.nlo = {cur.nlo[QUO_W-2:0], 1'b0};
    if (sh >= {1'b0, dvs}) begin
      res.rem = sh - {1'b0, dvs};
      res.quo = {cur.quo[QUO_W-2:0], 1'b1};
    end else begin
      res.rem = sh;
      res.quo = {cur.quo[QUO_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hdl/dpr_if.sv
// Stream interfaces: disparity pixel in, reprojected point out.
`default_nettype none
interface dpr_pix_if;
  import dpr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [11:0]               col;
  logic [11:0]               line;
  logic [DISPARITY_BITS-1:0] raw_disparity;
  logic [7:0]                pixel_blue;
  logic [7:0]                pixel_green;
  logic [7:0]                pixel_red;
  modport source (output valid, col, line, raw_disparity, pixel_blue, pixel_green, pixel_red,
                  input ready);
  modport sink   (input valid, col, line, raw_disparity, pixel_blue, pixel_green, pixel_red,
                  output ready);
endinterface

interface dpr_pt_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [30:0] point_z;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  modport source (output valid, point_x, point_y, point_z, out_red, out_green, out_blue,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, out_red, out_green, out_blue,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/disparity_to_point_reprojection.sv
// Top level: pipelined stereo disparity to 3-D point reprojection.
// Structure: 31 register stages per point (5 arithmetic, 25 divider steps, output).
// Throughput: one beat per cycle while the output is not stalled; the three divider lanes
// take one quotient bit per stage.
// Reset (rst_n low, synchronous): all stage valid bits and the output valid clear,
// configuration registers return to their default camera values.
`default_nettype none
module disparity_to_point_reprojection (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  dpr_pix_if.sink                        in_pix,
  dpr_pt_if.source                       out_pt,
  input  wire logic                      cfg_we,
  input  wire logic [dpr_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [dpr_pkg::CFG_W-1:0] cfg_data
);
  import dpr_pkg::*;

  // ---------------- configuration registers ----------------
  logic [12:0] image_width_r, image_height_r;
  logic [19:0] focal_r, baseline_r;
  logic [6:0]  divisor_r;
  logic [15:0] max_dist_r;
  logic        color_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
      focal_r        <= RST_FOCAL;
      baseline_r     <= RST_BASELINE;
      divisor_r      <= RST_DIVISOR;
      max_dist_r     <= RST_MAX_DIST;
      color_src_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[12:0];
        REG_FOCAL:        focal_r        <= cfg_data;
        REG_BASELINE:     baseline_r     <= cfg_data;
        REG_DIVISOR:      divisor_r      <= cfg_data[6:0];
        REG_MAX_DIST:     max_dist_r     <= cfg_data[15:0];
        REG_COLOR_SRC:    color_src_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together; it holds only when the output beat is stuck.
  logic en;
  assign en = !out_pt.valid || out_pt.ready;
  assign in_pix.ready = en;

  // ---------------- stage A: input, disparity check, offsets, B*v ----------------
  logic              a_valid_r;
  logic [DMAG_W-1:0] a_d_r;
  logic [12:0]       a_magx_r, a_magy_r;
  logic              a_negx_r, a_negy_r;
  logic [26:0]       a_bv_r;
  logic [23:0]       a_rgb_r;

  logic        in_pos;
  logic [13:0] twice_x, twice_y;
  logic [6:0]  v_eff;
  assign in_pos  = !in_pix.raw_disparity[DISPARITY_BITS-1] && (in_pix.raw_disparity != '0);
  assign twice_x = {1'b0, in_pix.col, 1'b0};
  assign twice_y = {1'b0, in_pix.line, 1'b0};
  assign v_eff   = (divisor_r == '0) ? 7'd1 : divisor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_pix.valid && in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r <= in_pix.raw_disparity[DMAG_W-1:0];
      if (twice_x >= {1'b0, image_width_r}) begin
        a_magx_r <= 13'(twice_x - {1'b0, image_width_r});
        a_negx_r <= 1'b0;
      end else begin
        a_magx_r <= 13'({1'b0, image_width_r} - twice_x);
        a_negx_r <= 1'b1;
      end
      if (twice_y >= {1'b0, image_height_r}) begin
        a_magy_r <= 13'(twice_y - {1'b0, image_height_r});
        a_negy_r <= 1'b0;
      end else begin
        a_magy_r <= 13'({1'b0, image_height_r} - twice_y);
        a_negy_r <= 1'b1;
      end
      a_bv_r  <= baseline_r * v_eff;
      a_rgb_r <= {in_pix.pixel_red, in_pix.pixel_green, in_pix.pixel_blue};
    end
  end

  // ---------------- stage B: numerators ----------------
  // Depth: f*B*v / (d<<8). Lateral: |2p - extent| * B*v / (d<<1).
  logic             b_valid_r;
  logic [NUM_W-1:0] b_nz_r, b_nx_r, b_ny_r;
  logic [DIV_W-1:0] b_dz_r, b_dl_r;
  logic             b_negx_r, b_negy_r;
  logic [23:0]      b_rgb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_nz_r   <= NUM_W'(focal_r) * NUM_W'(a_bv_r);
      b_nx_r   <= NUM_W'(a_magx_r) * NUM_W'(a_bv_r);
      b_ny_r   <= NUM_W'(a_magy_r) * NUM_W'(a_bv_r);
      b_dz_r   <= {1'b0, a_d_r, 8'd0};
      b_dl_r   <= {8'd0, a_d_r, 1'b0};
      b_negx_r <= a_negx_r;
      b_negy_r <= a_negy_r;
      b_rgb_r  <= a_rgb_r;
    end
  end

  // ---------------- stage C: overflow screen and divider seed ----------------
  // A quotient of 2^25 or more is far beyond any kept distance: flag it and drop later.
  logic [NUM_W-QUO_W-1:0] hz, hx, hy;
  assign hz = b_nz_r[NUM_W-1:QUO_W];
  assign hx = b_nx_r[NUM_W-1:QUO_W];
  assign hy = b_ny_r[NUM_W-1:QUO_W];

  // Divider pipeline arrays: index 0 is the seed, index QUO_W the finished quotient.
  logic             dv_valid_r [QUO_W+1];
  logic             dv_ovf_r   [QUO_W+1];
  logic             dv_negx_r  [QUO_W+1];
  logic             dv_negy_r  [QUO_W+1];
  logic [23:0]      dv_rgb_r   [QUO_W+1];
  logic [DIV_W-1:0] dv_dz_r    [QUO_W+1];
  logic [DIV_W-1:0] dv_dl_r    [QUO_W+1];
  div_lane_t        dv_z_r     [QUO_W+1];
  div_lane_t        dv_x_r     [QUO_W+1];
  div_lane_t        dv_y_r     [QUO_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QUO_W; k++) dv_valid_r[k] <= 1'b0;
    end else if (en) begin
      dv_valid_r[0] <= b_valid_r;
      for (int k = 1; k <= QUO_W; k++) dv_valid_r[k] <= dv_valid_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_ovf_r[0]  <= ({1'b0, hz} >= REM_W'(b_dz_r)) || ({1'b0, hx} >= REM_W'(b_dl_r)) ||
                      ({1'b0, hy} >= REM_W'(b_dl_r));
      dv_negx_r[0] <= b_negx_r;
      dv_negy_r[0] <= b_negy_r;
      dv_rgb_r[0]  <= b_rgb_r;
      dv_dz_r[0]   <= b_dz_r;
      dv_dl_r[0]   <= b_dl_r;
      dv_z_r[0]    <= '{rem: REM_W'(hz), nlo: b_nz_r[QUO_W-1:0], quo: '0};
      dv_x_r[0]    <= '{rem: REM_W'(hx), nlo: b_nx_r[QUO_W-1:0], quo: '0};
      dv_y_r[0]    <= '{rem: REM_W'(hy), nlo: b_ny_r[QUO_W-1:0], quo: '0};
      // Advance one quotient bit per stage in each lane.
      for (int k = 1; k <= QUO_W; k++) begin
        dv_ovf_r[k]  <= dv_ovf_r[k-1];
        dv_negx_r[k] <= dv_negx_r[k-1];
        dv_negy_r[k] <= dv_negy_r[k-1];
        dv_rgb_r[k]  <= dv_rgb_r[k-1];
        dv_dz_r[k]   <= dv_dz_r[k-1];
        dv_dl_r[k]   <= dv_dl_r[k-1];
        dv_z_r[k]    <= div_step(dv_z_r[k-1], dv_dz_r[k-1]);
        dv_x_r[k]    <= div_step(dv_x_r[k-1], dv_dl_r[k-1]);
        dv_y_r[k]    <= div_step(dv_y_r[k-1], dv_dl_r[k-1]);
      end
    end
  end

  // ---------------- stage E1: squares, box check, ramp numerator ----------------
  logic [QUO_W-1:0] qz, qx, qy;
  logic [23:0]      lim;
  assign qz  = dv_z_r[QUO_W].quo;
  assign qx  = dv_x_r[QUO_W].quo;
  assign qy  = dv_y_r[QUO_W].quo;
  assign lim = {max_dist_r, 8'd0};

  logic                 e1_valid_r, e1_keep_r, e1_zbig_r, e1_negx_r, e1_negy_r;
  logic [2*QUO_W-1:0]   e1_zz_r, e1_xx_r, e1_yy_r;
  logic [31:0]          e1_lim2_r;
  logic [13:0]          e1_t_r;
  logic [QUO_W-1:0]     e1_z_r, e1_x_r, e1_y_r;
  logic [23:0]          e1_rgb_r;

  logic [29:0] ramp_num;
  assign ramp_num = 30'({qz[21:0], 8'd0} - {8'd0, qz[21:0]}) + 30'(RAMP_ROUND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r <= 1'b0;
    end else if (en) begin
      e1_valid_r <= dv_valid_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_keep_r <= !dv_ovf_r[QUO_W] && (qz <= QUO_W'(lim)) && (qx <= QUO_W'(lim)) &&
                   (qy <= QUO_W'(lim));
      e1_zz_r   <= qz * qz;
      e1_xx_r   <= qx * qx;
      e1_yy_r   <= qy * qy;
      e1_lim2_r <= max_dist_r * max_dist_r;
      e1_zbig_r <= qz >= QUO_W'(RAMP_FULL);
      e1_t_r    <= ramp_num[29:16];
      e1_z_r    <= qz;
      e1_x_r    <= qx;
      e1_y_r    <= qy;
      e1_negx_r <= dv_negx_r[QUO_W];
      e1_negy_r <= dv_negy_r[QUO_W];
      e1_rgb_r  <= dv_rgb_r[QUO_W];
    end
  end

  // ---------------- stage E2: sphere check, reciprocal estimate ----------------
  logic                 e2_valid_r, e2_keep_r, e2_zbig_r;
  logic [13:0]          e2_t_r;
  logic [7:0]           e2_q_r;
  logic [31:0]          e2_x_r, e2_y_r;
  logic [30:0]          e2_z_r;
  logic [23:0]          e2_rgb_r;

  logic [2*QUO_W+1:0] sum_sq;
  logic [24:0]        recip_prod;
  assign sum_sq     = (2*QUO_W+2)'(e1_zz_r) + (2*QUO_W+2)'(e1_xx_r) + (2*QUO_W+2)'(e1_yy_r);
  assign recip_prod = e1_t_r * RECIP_50;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_valid_r <= 1'b0;
    end else if (en) begin
      e2_valid_r <= e1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_keep_r <= e1_keep_r && (sum_sq <= (2*QUO_W+2)'({e1_lim2_r, 16'd0}));
      e2_zbig_r <= e1_zbig_r;
      e2_t_r    <= e1_t_r;
      e2_q_r    <= recip_prod[23:16];
      e2_x_r    <= e1_negx_r ? 32'(-{7'd0, e1_x_r}) : {7'd0, e1_x_r};
      e2_y_r    <= e1_negy_r ? 32'(-{7'd0, e1_y_r}) : {7'd0, e1_y_r};
      e2_z_r    <= {6'd0, e1_z_r};
      e2_rgb_r  <= e1_rgb_r;
    end
  end

  // ---------------- output register: ramp correction, colour select ----------------
  logic [13:0] q50, rem50;
  logic [7:0]  red_ramp;
  assign q50      = {e2_q_r, 5'd0} + {1'b0, e2_q_r, 4'd0} + {5'd0, e2_q_r, 1'b0};
  assign rem50    = e2_t_r - q50;
  assign red_ramp = e2_zbig_r ? 8'd255 : ((rem50 >= 14'd50) ? e2_q_r + 8'd1 : e2_q_r);

  logic        out_valid_r;
  logic [31:0] out_x_r, out_y_r;
  logic [30:0] out_z_r;
  logic [7:0]  out_r_r, out_g_r, out_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e2_valid_r && e2_keep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= e2_x_r;
      out_y_r <= e2_y_r;
      out_z_r <= e2_z_r;
      if (color_src_r) begin
        out_r_r <= e2_rgb_r[23:16];
        out_g_r <= e2_rgb_r[15:8];
        out_b_r <= e2_rgb_r[7:0];
      end else begin
        out_r_r <= red_ramp;
        out_g_r <= GREEN_RAMP;
        out_b_r <= 8'd255 - red_ramp;
      end
    end
  end

  assign out_pt.valid     = out_valid_r;
  assign out_pt.point_x   = out_x_r;
  assign out_pt.point_y   = out_y_r;
  assign out_pt.point_z   = out_z_r;
  assign out_pt.out_red   = out_r_r;
  assign out_pt.out_green = out_g_r;
  assign out_pt.out_blue  = out_b_r;

endmodule
`default_nettype wire

// File: bench/tb_disparity_to_point_reprojection.sv
// Self-checking bench for the disparity to point reprojection pipeline.
`default_nettype none
module tb_disparity_to_point_reprojection;
  import dpr_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] z;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } point_t;

  // Scoreboard: mirrors the camera registers, predicts each kept point and
  // holds the predicted points in arrival order.
  class point_scoreboard;
    longint unsigned width, height, focal, baseline, divisor, max_dist, color_src;
    point_t          points_due[$];
    int              errors;

    function new();
      width = 640; height = 480; focal = 184714; baseline = 35389;
      divisor = 16; max_dist = 25600; color_src = 1; errors = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, longint unsigned val);
      case (idx)
        REG_IMAGE_WIDTH:  width = val & 'h1FFF;
        REG_IMAGE_HEIGHT: height = val & 'h1FFF;
        REG_FOCAL:        focal = val & 'hFFFFF;
        REG_BASELINE:     baseline = val & 'hFFFFF;
        REG_DIVISOR:      divisor = val & 'h7F;
        REG_MAX_DIST:     max_dist = val & 'hFFFF;
        REG_COLOR_SRC:    color_src = val & 1;
        default: ;
      endcase
    endfunction

    // Offset from the image center times B*v/d, truncated toward zero.
    function longint unsigned offset_mag(longint unsigned pos, longint unsigned extent,
                                         longint unsigned bv, longint unsigned d,
                                         output bit neg);
      longint unsigned twice;
      twice = pos * 2;
      neg = twice < extent;
      return ((neg ? extent - twice : twice - extent) * bv) / (2 * d);
    endfunction

    // Note an accepted pixel beat: queue its point if it survives the range gate.
    function void note_pixel(logic [11:0] c, logic [11:0] l, logic [15:0] raw,
                             logic [7:0] pb, logic [7:0] pg, logic [7:0] pr);
      longint unsigned d, v, bv, z, mx, my, lim, red;
      bit              nx, ny;
      point_t          p;
      d = raw;
      if (raw == 0 || raw[15]) return;     // non-positive disparity: no point
      v = (divisor == 0) ? 1 : divisor;
      bv = baseline * v;
      z = (focal * bv) / (d << 8);
      mx = offset_mag(c, width, bv, d, nx);
      my = offset_mag(l, height, bv, d, ny);
      lim = max_dist << 8;
      if (z > lim || mx > lim || my > lim) return;
      if (mx * mx + my * my + z * z > lim * lim) return;
      p.x = nx ? 32'(64'd0 - mx) : 32'(mx);
      p.y = ny ? 32'(64'd0 - my) : 32'(my);
      p.z = 31'(z);
      if (color_src != 0) begin
        p.red = pr; p.green = pg; p.blue = pb;
      end else begin
        if (z >= (64'd50 << 16)) red = 255;
        else red = (255 * z + (64'd25 << 16)) / (64'd50 << 16);
        p.red = 8'(red); p.green = 8'd128; p.blue = 8'(255 - red);
      end
      points_due.insert(points_due.size(), p);
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (points_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected point x=%h y=%h z=%h", got.x, got.y, got.z);
        return;
      end
      want = points_due.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display("point mismatch: exp x=%h y=%h z=%h rgb=%h/%h/%h got x=%h y=%h z=%h rgb=%h/%h/%h",
                   want.x, want.y, want.z, want.red, want.green, want.blue,
                   got.x, got.y, got.z, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dpr_pix_if pix ();
  dpr_pt_if  pt ();

  disparity_to_point_reprojection dut (
    .clk(clk), .rst_n(rst_n), .in_pix(pix), .out_pt(pt),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  point_scoreboard sb = new();

  int send_idle_pct;    // chance the sender leaves a cycle empty
  int recv_stall_pct;   // chance the receiver drops ready
  int hold_req;         // request a long receiver hold-off
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the pipeline hangs.
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off to back the pipe up.
  always @(posedge clk) begin
    if (!rst_n) begin
      pt.ready <= 1'b0;
    end else if (hold_req != 0) begin
      hold_req = 0;
      hold_left = 300;
      pt.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pt.ready <= 1'b0;
    end else begin
      pt.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitors: predict on every accepted pixel beat, check every point beat.
  always @(posedge clk) begin
    if (rst_n && pix.valid && pix.ready)
      sb.note_pixel(pix.col, pix.line, pix.raw_disparity,
                    pix.pixel_blue, pix.pixel_green, pix.pixel_red);
    if (rst_n && pt.valid && pt.ready)
      sb.check_point('{pt.point_x, pt.point_y, pt.point_z,
                       pt.out_red, pt.out_green, pt.out_blue});
  end

  // Offer one pixel beat and hold it until accepted.
  task automatic send_pixel(logic [11:0] c, logic [11:0] l, logic [15:0] raw,
                            logic [7:0] pb, logic [7:0] pg, logic [7:0] pr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.col <= c; pix.line <= l; pix.raw_disparity <= raw;
    pix.pixel_blue <= pb; pix.pixel_green <= pg; pix.pixel_red <= pr;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
  endtask

  // Random pixel: mostly on-image with disparity spread over octaves so that
  // near and far points both show up, the rest raw noise over the full fields.
  task automatic send_random_pixel();
    int          sh;
    int          wlim, hlim;
    logic [15:0] raw;
    wlim = (sb.width > 4095) ? 4095 : int'(sb.width);
    hlim = (sb.height > 4095) ? 4095 : int'(sb.height);
    if ($urandom_range(0, 99) < 85) begin
      sh = $urandom_range(0, 14);
      raw = 16'($urandom_range(1 << sh, (2 << sh) - 1));
    end else begin
      raw = 16'($urandom_range(0, 65535));
    end
    send_pixel(($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                           : 12'($urandom_range(0, wlim)),
               ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                           : 12'($urandom_range(0, hlim)),
               raw, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop valid, let every queued point out, then wait out the pipe latency so
  // that a dropped point cannot still be in flight when registers change.
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (sb.points_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_camera(longint unsigned w, longint unsigned h, longint unsigned f,
                             longint unsigned b, longint unsigned v, longint unsigned m,
                             longint unsigned cs);
    longint unsigned vals[7];
    vals = '{w, h, f, b, v, m, cs};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data <= CFG_W'(vals[i]);
      sb.set_reg(IDX_W'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int n);
    repeat (n) send_random_pixel();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    pix.valid <= 1'b0; pix.col <= '0; pix.line <= '0; pix.raw_disparity <= '0;
    pix.pixel_blue <= '0; pix.pixel_green <= '0; pix.pixel_red <= '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0; hold_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset camera, field extremes, zero and negative disparity.
    send_pixel(12'd0, 12'd0, 16'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(12'd320, 12'd240, 16'hFFFF, 8'd255, 8'd255, 8'd255);
    send_pixel(12'd320, 12'd240, 16'h8000, 8'd1, 8'd2, 8'd3);
    send_pixel(12'd320, 12'd240, 16'h7FFF, 8'd255, 8'd0, 8'd255);
    send_pixel(12'd320, 12'd240, 16'd1, 8'd9, 8'd9, 8'd9);
    send_pixel(12'd320, 12'd240, 16'd63, 8'd10, 8'd20, 8'd30);
    send_pixel(12'd320, 12'd240, 16'd64, 8'd10, 8'd20, 8'd30);
    send_pixel(12'd0, 12'd0, 16'd4000, 8'd0, 8'd255, 8'd0);
    send_pixel(12'd639, 12'd479, 16'd4000, 8'd255, 8'd0, 8'd255);
    send_pixel(12'd4095, 12'd4095, 16'd4000, 8'd7, 8'd7, 8'd7);
    send_pixel(12'd4095, 12'd4095, 16'h7FFF, 8'd7, 8'd7, 8'd7);
    send_pixel(12'd0, 12'd4095, 16'h4000, 8'd128, 8'd64, 8'd32);
    send_pixel(12'd4095, 12'd0, 16'h2AAA, 8'd1, 8'd1, 8'd1);
    send_pixel(12'hAAA, 12'h555, 16'h5555, 8'hAA, 8'h55, 8'hAA);
    send_pixel(12'h555, 12'hAAA, 16'h0AAA, 8'h55, 8'hAA, 8'h55);
    run_random(170);
    drain();

    // Extreme camera, depth ramp, sender idling.
    load_camera(4096, 4096, 1048575, 1, 64, 65535, 0);
    send_idle_pct = 52;
    send_pixel(12'd2048, 12'd2048, 16'd1, 8'd0, 8'd0, 8'd0);
    send_pixel(12'd0, 12'd0, 16'd1, 8'd0, 8'd0, 8'd0);
    run_random(180);
    drain();

    // Opposite extreme, receiver stalling, and one long hold-off that backs
    // the pipe up while the sender keeps offering.
    load_camera(1, 1, 1, 1048575, 1, 1000, 1);
    send_idle_pct = 0; recv_stall_pct = 52;
    hold_req = 1;
    run_random(180);
    drain();

    // Zero divisor and zero focal, ramp colors, both sides idling.
    load_camera(640, 480, 0, 35389, 0, 25600, 0);
    send_idle_pct = 23; recv_stall_pct = 23;
    run_random(90);
    drain();
    load_camera(640, 480, 184714, 35389, 0, 25600, 0);
    run_random(90);
    drain();

    // Zero range: only the origin could pass.
    load_camera(640, 480, 184714, 35389, 16, 0, 1);
    send_idle_pct = 0; recv_stall_pct = 0;
    send_pixel(12'd320, 12'd240, 16'd100, 8'd1, 8'd2, 8'd3);
    run_random(40);
    drain();

    // Mid-range camera, ramp colors, mixed idling.
    load_camera(1280, 720, 256000, 7864, 32, 5120, 0);
    send_idle_pct = 23; recv_stall_pct = 52;
    run_random(180);
    drain();

    if (sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
